// ===== rtl/pdlz_pkg.sv =====
package pdlz_pkg;

    // record status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_LIMIT  = 2'd1;
    localparam logic [1:0] STATUS_BADREF = 2'd2;
    localparam logic [1:0] STATUS_TRUNC  = 2'd3;

    // token decoding constants
    localparam logic [7:0]  SPACE_CHAR     = 8'h20;
    localparam logic [7:0]  ASCII_MASK     = 8'h7f;
    localparam logic [7:0]  SPACE_PAIR_MIN = 8'hc0;
    localparam logic [7:0]  LIT_RUN_MIN    = 8'd1;
    localparam logic [7:0]  LIT_RUN_MAX    = 8'd8;
    localparam logic [3:0]  COPY_LEN_BASE  = 4'd3;
    localparam logic [15:0] LIMIT_RESET    = 16'd4096;

    // front to back command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // what the back end does for one accepted word
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LIT,
        KIND_SPACE,
        KIND_COPY
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [3:0]  count;
        logic [10:0] distance;
        logic [1:0]  status;
        logic        last;
    } cmd_t;

endpackage

// ===== rtl/pdlz_in_if.sv =====
interface pdlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/pdlz_out_if.sv =====
interface pdlz_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_end;
    logic        record_end;
    logic [15:0] decoded_length;
    logic [1:0]  status;

    modport source (output valid, output out_byte, output byte_valid, output run_end,
                    output record_end, output decoded_length, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_end,
                    input record_end, input decoded_length, input status,
                    output ready);
endinterface

// ===== rtl/palmdoc_lz77_decompressor.sv =====
// A result word passes the queue slot, the command register and the output register.
// Throughput: one result word per cycle while the output is ready; a literal causes one
// result, a space pair two (one at the limit), a back reference 3..10; words causing
// none are queued only at record end; a 4-entry queue sits between.
// Reset clears all control state and sets the output limit to 4096; the history
// window is not cleared.
module palmdoc_lz77_decompressor #(
    parameter int WINDOW_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    pdlz_in_if.sink     cmp_bytes,
    pdlz_out_if.source  dec_bytes
);
    import pdlz_pkg::*;

    logic push, full, pop, empty;
    cmd_t push_cmd, head;

    // token classifier and record state
    pdlz_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmp_bytes   (cmp_bytes),
        .push        (push),
        .push_cmd    (push_cmd),
        .full        (full)
    );

    // command queue
    pdlz_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // copy engine and history window
    pdlz_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .dec_bytes (dec_bytes)
    );

endmodule

// ===== rtl/pdlz_front.sv =====
module pdlz_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    pdlz_in_if.sink        cmp_bytes,
    output logic           push,
    output pdlz_pkg::cmd_t push_cmd,
    input  logic           full
);
    import pdlz_pkg::*;

    logic [15:0] limit_reg;
    logic [15:0] wc_reg, wc_next;
    logic [3:0]  lp_reg, lp_next;
    logic        pair_reg, pair_next;
    logic [7:0]  first_reg, first_next;
    logic        stop_reg, stop_next;
    logic [1:0]  st_reg, st_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [13:0] code;
    logic [10:0] dist_c;
    logic [3:0]  len_c;
    logic [16:0] sum1, sum2, sumc, limit_x;
    kind_t       kind;
    logic [7:0]  b0, b1;
    logic [3:0]  cnt;
    logic [10:0] copy_dist;

    // first nonzero status of a record sticks
    function automatic logic [1:0] set_status(input logic [1:0] cur, input logic [1:0] code_in);
        set_status = (cur == STATUS_OK) ? code_in : cur;
    endfunction

    assign accept          = cmp_bytes.valid && !full;
    assign cmp_bytes.ready = !full;
    assign b               = cmp_bytes.in_byte;
    assign last            = cmp_bytes.in_last;

    assign code    = {first_reg[5:0], b};
    assign dist_c  = code[13:3];
    assign len_c   = {1'b0, code[2:0]} + COPY_LEN_BASE;
    assign limit_x = {1'b0, limit_reg};
    assign sum1    = {1'b0, wc_reg} + 17'd1;
    assign sum2    = {1'b0, wc_reg} + 17'd2;
    assign sumc    = {1'b0, wc_reg} + {13'd0, len_c};

    // classify the word against the current record state
    always_comb
    begin
        wc_next    = wc_reg;
        lp_next    = lp_reg;
        pair_next  = pair_reg;
        first_next = first_reg;
        stop_next  = stop_reg;
        st_next    = st_reg;
        kind       = KIND_NONE;
        b0         = b;
        b1         = b & ASCII_MASK;
        cnt        = 4'd0;
        copy_dist  = 11'd0;

        // limit may already be met (or lowered) before this word
        if (!stop_reg && wc_reg >= limit_reg)
        begin
            stop_next = 1'b1;
            st_next   = set_status(st_next, STATUS_LIMIT);
        end

        if (!stop_next)
        begin
            if (lp_reg != 4'd0)
            begin
                lp_next = lp_reg - 4'd1;
                kind    = KIND_LIT;
                cnt     = 4'd1;
                wc_next = sum1[15:0];
                if (sum1 >= limit_x)
                begin
                    stop_next = 1'b1;
                    st_next   = set_status(st_next, STATUS_LIMIT);
                end
            end
            else if (pair_reg)
            begin
                pair_next = 1'b0;
                if (dist_c == 11'd0 || {5'd0, dist_c} > wc_reg || sumc > limit_x)
                begin
                    stop_next = 1'b1;
                    st_next   = set_status(st_next, STATUS_BADREF);
                end
                else
                begin
                    kind      = KIND_COPY;
                    cnt       = len_c;
                    copy_dist = dist_c;
                    wc_next   = sumc[15:0];
                    if (sumc >= limit_x)
                    begin
                        stop_next = 1'b1;
                        st_next   = set_status(st_next, STATUS_LIMIT);
                    end
                end
            end
            else if (b >= LIT_RUN_MIN && b <= LIT_RUN_MAX)
            begin
                lp_next = b[3:0];
            end
            else if (b <= ASCII_MASK)
            begin
                kind    = KIND_LIT;
                cnt     = 4'd1;
                wc_next = sum1[15:0];
                if (sum1 >= limit_x)
                begin
                    stop_next = 1'b1;
                    st_next   = set_status(st_next, STATUS_LIMIT);
                end
            end
            else if (b >= SPACE_PAIR_MIN)
            begin
                kind = KIND_SPACE;
                b0   = SPACE_CHAR;
                if (sum1 >= limit_x)
                begin
                    // second byte does not fit
                    cnt       = 4'd1;
                    wc_next   = sum1[15:0];
                    stop_next = 1'b1;
                    st_next   = set_status(st_next, STATUS_LIMIT);
                end
                else
                begin
                    cnt     = 4'd2;
                    wc_next = sum2[15:0];
                    if (sum2 >= limit_x)
                    begin
                        stop_next = 1'b1;
                        st_next   = set_status(st_next, STATUS_LIMIT);
                    end
                end
            end
            else
            begin
                pair_next  = 1'b1;
                first_next = b;
            end
        end

        if (last && !stop_next && (lp_next != 4'd0 || pair_next))
            st_next = set_status(st_next, STATUS_TRUNC);

        push              = accept && (cnt != 4'd0 || last);
        push_cmd.kind     = kind;
        push_cmd.byte0    = b0;
        push_cmd.byte1    = b1;
        push_cmd.count    = (cnt == 4'd0) ? 4'd1 : cnt;
        push_cmd.distance = copy_dist;
        push_cmd.status   = st_next;
        push_cmd.last     = last;

        // record end clears the decode state
        if (last)
        begin
            wc_next    = 16'd0;
            lp_next    = 4'd0;
            pair_next  = 1'b0;
            first_next = 8'd0;
            stop_next  = 1'b0;
            st_next    = STATUS_OK;
        end
    end

    // decode state and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            wc_reg    <= 16'd0;
            lp_reg    <= 4'd0;
            pair_reg  <= 1'b0;
            first_reg <= 8'd0;
            stop_reg  <= 1'b0;
            st_reg    <= STATUS_OK;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (accept)
            begin
                wc_reg    <= wc_next;
                lp_reg    <= lp_next;
                pair_reg  <= pair_next;
                first_reg <= first_next;
                stop_reg  <= stop_next;
                st_reg    <= st_next;
            end
        end
    end

    a_stop_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> st_reg != STATUS_OK)
        else $error("decode stopped without a status");

    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !(pair_reg && lp_reg != 4'd0))
        else $error("literal run and reference pending together");

endmodule

// ===== rtl/pdlz_queue.sv =====
module pdlz_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pdlz_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output pdlz_pkg::cmd_t head,
    output logic           empty
);
    import pdlz_pkg::*;

    localparam int QCNT_W = QPTR_W + 1;

    cmd_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command queue underflow");

endmodule

// ===== rtl/pdlz_back.sv =====
module pdlz_back #(
    parameter int WINDOW_DEPTH = 2048
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pdlz_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    pdlz_out_if.source     dec_bytes
);
    import pdlz_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_DEPTH - 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [15:0] cnt_reg;
    logic [AW-1:0] waddr_reg, waddr_next, waddr_inc;
    logic [AW-1:0] src_reg, src_inc, rd_addr;
    logic [7:0]  rd_data_reg;
    logic [7:0]  last_byte_reg;
    logic        ov_reg;
    logic [7:0]  ob_reg;
    logic        bv_reg, re_reg, rec_reg;
    logic [15:0] len_reg;
    logic [1:0]  st_reg;

    logic [7:0]  mem [WINDOW_DEPTH];

    logic        advance, finishing, record_done, emit_valid, wr_en, rd_en;
    logic [7:0]  emit_byte;
    logic [15:0] cnt_inc;
    logic [AW:0] diff, diff_wrap;

    assign advance     = state_reg == ST_RUN && (!ov_reg || dec_bytes.ready);
    assign finishing   = advance && cmd_reg.count == 4'd1;
    assign record_done = finishing && cmd_reg.last;
    assign pop         = !empty && (state_reg == ST_IDLE || finishing);
    assign emit_valid  = cmd_reg.kind != KIND_NONE;
    assign wr_en       = advance && emit_valid;
    assign cnt_inc     = cnt_reg + 16'd1;

    // byte for the current result; distance one takes the byte just written
    always_comb
    begin
        case (cmd_reg.kind) inside
            KIND_LIT, KIND_SPACE: emit_byte = cmd_reg.byte0;
            KIND_COPY:            emit_byte = (cmd_reg.distance == 11'd1) ? last_byte_reg
                                                                        : rd_data_reg;
            default:              emit_byte = 8'd0;
        endcase
    end

    // window write pointer, wraps at the window depth and returns to zero at record end
    assign waddr_inc  = (waddr_reg == ADDR_LAST) ? '0 : waddr_reg + 1'b1;
    assign src_inc    = (src_reg == ADDR_LAST) ? '0 : src_reg + 1'b1;

    always_comb
    begin
        if (record_done)
            waddr_next = '0;
        else if (wr_en)
            waddr_next = waddr_inc;
        else
            waddr_next = waddr_reg;
    end

    // history read: first source at command load, then one ahead per byte
    assign diff      = {1'b0, waddr_next} - (AW+1)'(head.distance);
    assign diff_wrap = diff + (AW+1)'(WINDOW_DEPTH);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = src_inc;
        if (pop && head.kind == KIND_COPY)
        begin
            rd_en   = 1'b1;
            rd_addr = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
        end
        else if (advance && cmd_reg.kind == KIND_COPY && cmd_reg.count != 4'd1)
        begin
            rd_en = 1'b1;
        end
    end

    // history window
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr_reg] <= emit_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            cnt_reg       <= 16'd0;
            waddr_reg     <= '0;
            src_reg       <= '0;
            last_byte_reg <= 8'd0;
            ov_reg        <= 1'b0;
            ob_reg        <= 8'd0;
            bv_reg        <= 1'b0;
            re_reg        <= 1'b0;
            rec_reg       <= 1'b0;
            len_reg       <= 16'd0;
            st_reg        <= STATUS_OK;
        end
        else
        begin
            waddr_reg <= waddr_next;
            if (rd_en)
                src_reg <= rd_addr;

            if (advance)
            begin
                ov_reg  <= 1'b1;
                ob_reg  <= emit_byte;
                bv_reg  <= emit_valid;
                re_reg  <= cmd_reg.count == 4'd1;
                rec_reg <= record_done;
                len_reg <= emit_valid ? cnt_inc : cnt_reg;
                st_reg  <= cmd_reg.status;
                if (record_done)
                    cnt_reg <= 16'd0;
                else if (wr_en)
                    cnt_reg <= cnt_inc;
                if (wr_en)
                    last_byte_reg <= emit_byte;
                // a pop loads the next command below instead
                if (!pop)
                begin
                    cmd_reg.count <= cmd_reg.count - 4'd1;
                    if (cmd_reg.kind == KIND_SPACE)
                        cmd_reg.byte0 <= cmd_reg.byte1;
                end
            end
            else if (ov_reg && dec_bytes.ready)
            begin
                ov_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg   <= head;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (pop)
                        cmd_reg <= head;
                    else if (finishing)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign dec_bytes.valid          = ov_reg;
    assign dec_bytes.out_byte       = ob_reg;
    assign dec_bytes.byte_valid     = bv_reg;
    assign dec_bytes.run_end        = re_reg;
    assign dec_bytes.record_end     = rec_reg;
    assign dec_bytes.decoded_length = len_reg;
    assign dec_bytes.status         = st_reg;

    a_record_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && rec_reg |-> re_reg)
        else $error("record end without run end");

    a_empty_result_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !bv_reg |-> re_reg && rec_reg && ob_reg == 8'd0)
        else $error("byteless result outside record end");

endmodule
